// ----- rtl/ftft_pkg.sv -----
// Shared types, constants and the decay table for the fixed-timestep frame timer.
// Used by the timer core, the shared divider and the port checker.
package ftft_pkg;

    // decay table geometry
    localparam int unsigned DECAY_TABLE_DEPTH = 256;
    localparam int unsigned IDX_W             = $clog2(DECAY_TABLE_DEPTH);

    // Taylor series argument 8/depth in Q32
    localparam logic [63:0] DECAY_Y = (64'd8 << 32) / DECAY_TABLE_DEPTH;

    // fixed step used when the step register holds zero on a consume request
    localparam logic [23:0] DEFAULT_STEP_US = 24'd16667;
    localparam logic [16:0] ALPHA_ONE       = 17'd65536;

    // shared divider: quotient is known to fit DIV_Q_W bits
    localparam int unsigned DIV_Q_W   = 16;
    localparam int unsigned DIV_DEN_W = 27;
    localparam int unsigned DIV_NUM_W = (32 + IDX_W > 40) ? 32 + IDX_W : 40;
    localparam int unsigned DIV_REM_W = DIV_DEN_W + 1;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_Q_W + 1);

    // request kinds
    typedef enum logic [1:0] {
        KIND_FRAME   = 2'd0,
        KIND_CONSUME = 2'd1,
        KIND_DISCARD = 2'd2
    } t_kind;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_MAX_DELTA  = 2'd0,
        CFG_SMOOTHING  = 2'd1,
        CFG_TIME_SCALE = 2'd2,
        CFG_FIXED_STEP = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_Q_W-1:0] quo;
    } t_div_rsp;

    typedef logic [15:0] t_decay_tab [DECAY_TABLE_DEPTH];

    // long division by shift and subtract, used only while building the table
    function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int k = 63; k >= 0; k--) begin
            rem = {rem[63:0], num[k]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[k] = 1'b1;
            end
        end
        return quo;
    endfunction

    // 1 - exp(-8 i / depth) in Q0.16; exp built by a truncating Taylor series in Q32
    function automatic t_decay_tab build_decay_tab();
        logic [63:0] term;
        logic [63:0] b;
        logic [63:0] p;
        t_decay_tab  tab;
        term = 64'd1 << 32;
        b    = term;
        p    = term;
        for (int n = 1; n <= 24; n++) begin
            term = div_u64((term * DECAY_Y) >> 32, 64'(n));
            if ((n & 1) != 0) begin
                b = b - term;
            end else begin
                b = b + term;
            end
        end
        for (int i = 0; i < DECAY_TABLE_DEPTH; i++) begin
            tab[i] = 16'(17'd65536 - 17'((p + 64'd32768) >> 16));
            p      = (p * b + 64'h8000_0000) >> 32;
        end
        return tab;
    endfunction

    localparam t_decay_tab DECAY_TAB = build_decay_tab();

endpackage

// ----- rtl/ftft_div.sv -----
// Shared restoring divider for the frame timer, one quotient bit per cycle.
// Depends on ftft_pkg. Caller guarantees num < den * 2**DIV_Q_W.
module ftft_div import ftft_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [DIV_REM_W-1:0] r_rem;
    logic [DIV_Q_W-1:0]   r_low;
    logic [DIV_Q_W-1:0]   r_quo;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_done;

    logic [DIV_REM_W-1:0] trial;
    logic                 fits;

    // shift in the next numerator bit and try the subtraction
    assign trial = {r_rem[DIV_REM_W-2:0], r_low[DIV_Q_W-1]};
    assign fits  = trial >= DIV_REM_W'(r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem <= DIV_REM_W'(i_req.num >> DIV_Q_W);
                r_low <= i_req.num[DIV_Q_W-1:0];
                r_den <= i_req.den;
                r_cnt <= DIV_CNT_W'(DIV_Q_W);
            end else if (r_cnt != '0) begin
                r_rem  <= fits ? trial - DIV_REM_W'(r_den) : trial;
                r_low  <= {r_low[DIV_Q_W-2:0], 1'b0};
                r_quo  <= {r_quo[DIV_Q_W-2:0], fits};
                r_cnt  <= r_cnt - DIV_CNT_W'(1);
                r_done <= (r_cnt == DIV_CNT_W'(1));
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

// ----- rtl/fixed_timestep_frame_timer_core.sv -----
// Fixed-timestep frame timer core: sequencer, clocks, credit and output register.
// Depends on ftft_pkg and ftft_div.
//
// One request is worked on at a time; the input stalls from acceptance until its
// result is loaded into the output register, and reopens as that result becomes
// valid. A frame request runs eight steps, two of them through one shared 32x17
// multiplier, plus two passes of the shared divider (decay table index, then alpha).
// Each divider pass is skipped when it is not needed. A consume request uses the
// divider only when alpha needs it; a discard clears the credit without it, and an
// unused kind only recomputes alpha, with the divider when needed.
// A stalled output register holds the finished request back for as long as it stalls.
// The next request may be accepted while the previous result still waits in the
// output register. Configuration writes are taken at any time but are meant for idle
// periods.
module fixed_timestep_frame_timer_core import ftft_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_elapsed_us,
    input  logic        i_paused,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_delta_us,
    output logic [31:0] o_smooth_delta_us,
    output logic [47:0] o_game_time_us,
    output logic [47:0] o_unscaled_time_us,
    output logic [47:0] o_fixed_time_us,
    output logic [47:0] o_frame_total,
    output logic [47:0] o_fixed_step_total,
    output logic        o_step_due,
    output logic [16:0] o_alpha_q16,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLAMP,
        S_IDX,
        S_IDXW,
        S_SMUL,
        S_SUPD,
        S_SCALE,
        S_GAME,
        S_CONS,
        S_ALPHA,
        S_ALPHAW,
        S_DONE
    } t_state;

    t_state r_state;

    // configuration
    logic [31:0] r_max_delta;
    logic [23:0] r_tau;
    logic [15:0] r_scale;
    logic [23:0] r_fixed_step;

    // timer state
    logic signed [47:0] r_credit;
    logic [47:0] r_game;
    logic [47:0] r_real;
    logic [47:0] r_fixed;
    logic [31:0] r_smooth;
    logic [31:0] r_last_delta;
    logic [47:0] r_frames;
    logic [47:0] r_steps;

    // request working registers
    logic [1:0]  r_kind;
    logic [31:0] r_elapsed;
    logic        r_paused;
    logic [31:0] r_dt;
    logic [31:0] r_diff;
    logic        r_dt_ge;
    logic [16:0] r_factor;
    logic [48:0] r_prod;
    logic        r_due;
    logic [16:0] r_alpha;

    // output register
    logic        r_out_valid;
    logic [31:0] r_o_delta;
    logic [31:0] r_o_smooth;
    logic [47:0] r_o_game;
    logic [47:0] r_o_real;
    logic [47:0] r_o_fixed;
    logic [47:0] r_o_frames;
    logic [47:0] r_o_steps;
    logic        r_o_due;
    logic [16:0] r_o_alpha;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic        in_acc;
    logic        out_free;
    logic [31:0] mul_a;
    logic [16:0] mul_b;
    logic [48:0] mul_p;
    logic        idx_ok;
    logic [39:0] scaled;
    logic [23:0] cons_step;
    logic signed [48:0] credit_delta;
    logic signed [48:0] credit_sum;
    logic signed [47:0] credit_sat;
    logic        credit_pos;
    logic        credit_ge;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // decay table used only when dt stays below eight time constants
    assign idx_ok = (r_tau != '0) && (r_dt < 32'({r_tau, 3'b000}));

    // shared multiplier: smoothing step or time scaling
    always_comb begin
        if (r_state == S_SCALE) begin
            mul_a = r_dt;
            mul_b = r_paused ? 17'd0 : 17'(r_scale);
        end else begin
            mul_a = r_diff;
            mul_b = r_factor;
        end
        mul_p = 49'(mul_a) * 49'(mul_b);
    end

    assign scaled    = r_prod[47:8];
    assign cons_step = (r_fixed_step == '0) ? DEFAULT_STEP_US : r_fixed_step;

    // saturating credit update
    always_comb begin
        if (r_state == S_CONS) begin
            credit_delta = 49'sd0 - $signed(49'(cons_step));
        end else begin
            credit_delta = $signed(49'(scaled));
        end
        credit_sum = {r_credit[47], r_credit} + credit_delta;
        if (credit_sum[48] != credit_sum[47]) begin
            credit_sat = credit_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end else begin
            credit_sat = credit_sum[47:0];
        end
    end

    // credit against the fixed step
    assign credit_pos = !r_credit[47] && (r_credit != '0);
    assign credit_ge  = !r_credit[47] && (r_credit[46:0] >= 47'(r_fixed_step));

    // divider requests
    always_comb begin
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = '0;
        if (r_state == S_IDX && idx_ok) begin
            div_req.start = 1'b1;
            div_req.num   = DIV_NUM_W'(r_dt) * DIV_NUM_W'(DECAY_TABLE_DEPTH);
            div_req.den   = {r_tau, 3'b000};
        end else if (r_state == S_ALPHA && r_fixed_step != '0 && credit_pos && !credit_ge) begin
            div_req.start = 1'b1;
            div_req.num   = DIV_NUM_W'({r_credit[23:0], 16'd0});
            div_req.den   = DIV_DEN_W'(r_fixed_step);
        end
    end

    ftft_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // sequencer, timer state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_max_delta  <= 32'd250000;
            r_tau        <= 24'd100000;
            r_scale      <= 16'd256;
            r_fixed_step <= DEFAULT_STEP_US;
            r_credit     <= '0;
            r_game       <= '0;
            r_real       <= '0;
            r_fixed      <= '0;
            r_smooth     <= '0;
            r_last_delta <= '0;
            r_frames     <= '0;
            r_steps      <= '0;
        end else begin
            // result taken; S_DONE reloads the register itself
            if (r_state != S_DONE && r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_kind    <= i_kind;
                        r_elapsed <= i_elapsed_us;
                        r_paused  <= i_paused;
                        case (i_kind)
                            KIND_FRAME:   r_state <= S_CLAMP;
                            KIND_CONSUME: r_state <= S_CONS;
                            default:      r_state <= S_ALPHA;
                        endcase
                    end
                end
                S_CLAMP: begin
                    r_dt     <= (r_elapsed < r_max_delta) ? r_elapsed : r_max_delta;
                    r_real   <= 48'(r_real + 48'((r_elapsed < r_max_delta) ?
                                                 r_elapsed : r_max_delta));
                    r_frames <= 48'(r_frames + 48'd1);
                    r_state  <= S_IDX;
                end
                S_IDX: begin
                    r_dt_ge <= r_dt >= r_smooth;
                    r_diff  <= (r_dt >= r_smooth) ? r_dt - r_smooth : r_smooth - r_dt;
                    if (idx_ok) begin
                        r_state <= S_IDXW;
                    end else begin
                        r_factor <= ALPHA_ONE;
                        r_state  <= S_SMUL;
                    end
                end
                S_IDXW: begin
                    if (div_rsp.done) begin
                        r_factor <= 17'(DECAY_TAB[div_rsp.quo[IDX_W-1:0]]);
                        r_state  <= S_SMUL;
                    end
                end
                S_SMUL: begin
                    r_prod  <= mul_p;
                    r_state <= S_SUPD;
                end
                S_SUPD: begin
                    if (r_smooth == '0) begin
                        r_smooth <= r_dt;
                    end else if (r_dt_ge) begin
                        r_smooth <= r_smooth + 32'(r_prod >> 16);
                    end else begin
                        r_smooth <= r_smooth - 32'(r_prod >> 16);
                    end
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_prod  <= mul_p;
                    r_state <= S_GAME;
                end
                S_GAME: begin
                    r_credit     <= credit_sat;
                    r_game       <= 48'(r_game + 48'(scaled));
                    r_last_delta <= (scaled[39:32] != '0) ? 32'hFFFF_FFFF : scaled[31:0];
                    r_state      <= S_ALPHA;
                end
                S_CONS: begin
                    r_fixed_step <= cons_step;
                    r_credit     <= credit_sat;
                    r_last_delta <= 32'(cons_step);
                    r_fixed      <= 48'(r_fixed + 48'(cons_step));
                    r_steps      <= 48'(r_steps + 48'd1);
                    r_state      <= S_ALPHA;
                end
                S_ALPHA: begin
                    if (r_kind == KIND_DISCARD) begin
                        // discard clears the credit; status follows from zero credit
                        r_credit <= '0;
                        r_due    <= 1'b0;
                        r_alpha  <= '0;
                        r_state  <= S_DONE;
                    end else if (r_fixed_step == '0 || !credit_pos) begin
                        r_due   <= 1'b0;
                        r_alpha <= '0;
                        r_state <= S_DONE;
                    end else if (credit_ge) begin
                        r_due   <= 1'b1;
                        r_alpha <= ALPHA_ONE;
                        r_state <= S_DONE;
                    end else begin
                        r_due   <= 1'b0;
                        r_state <= S_ALPHAW;
                    end
                end
                S_ALPHAW: begin
                    if (div_rsp.done) begin
                        r_alpha <= 17'(div_rsp.quo);
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_delta   <= r_last_delta;
                        r_o_smooth  <= r_smooth;
                        r_o_game    <= r_game;
                        r_o_real    <= r_real;
                        r_o_fixed   <= r_fixed;
                        r_o_frames  <= r_frames;
                        r_o_steps   <= r_steps;
                        r_o_due     <= r_due;
                        r_o_alpha   <= r_alpha;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            // register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAX_DELTA:  r_max_delta  <= i_cfg_wdata;
                    CFG_SMOOTHING:  r_tau        <= i_cfg_wdata[23:0];
                    CFG_TIME_SCALE: r_scale      <= i_cfg_wdata[15:0];
                    CFG_FIXED_STEP: r_fixed_step <= i_cfg_wdata[23:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_in_stall         = (r_state != S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_delta_us         = r_o_delta;
    assign o_smooth_delta_us  = r_o_smooth;
    assign o_game_time_us     = r_o_game;
    assign o_unscaled_time_us = r_o_real;
    assign o_fixed_time_us    = r_o_fixed;
    assign o_frame_total      = r_o_frames;
    assign o_fixed_step_total = r_o_steps;
    assign o_step_due         = r_o_due;
    assign o_alpha_q16        = r_o_alpha;

endmodule

// ----- rtl/ftft_checker.sv -----
// Port-level checks for the frame timer core, attached by bind.
// Depends on ftft_pkg and fixed_timestep_frame_timer_core.
module ftft_checker import ftft_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_delta_us,
    input logic [47:0] o_game_time_us,
    input logic        o_step_due,
    input logic [16:0] o_alpha_q16
);

    // one request at a time: accepting a request closes the input
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input open right after a request was accepted");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_delta_us) && $stable(o_game_time_us)
             && $stable(o_alpha_q16)))
        else $error("stalled result changed");

    // a step is due exactly when alpha is saturated at one
    a_due_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_step_due == (o_alpha_q16 == ALPHA_ONE)))
        else $error("step_due and alpha disagree");

    a_alpha_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_alpha_q16 <= ALPHA_ONE))
        else $error("alpha above one");

    // a fresh result only appears while a request is being worked on
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a request in progress");

endmodule

bind fixed_timestep_frame_timer_core ftft_checker u_ftft_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_delta_us     (o_delta_us),
    .o_game_time_us (o_game_time_us),
    .o_step_due     (o_step_due),
    .o_alpha_q16    (o_alpha_q16)
);
